FILE: sv/gscd_pkg.sv
// ----------------------------------------------------------------------------
// gscd_pkg
// Shared constants, types and the byte-wide crc-16/modbus step for the gas
// sensor frame decoder.
// ----------------------------------------------------------------------------
package gscd_pkg;

   // frame layout
   localparam int PosWidth = 5;
   typedef logic [PosWidth-1:0] pos_type;

   localparam pos_type POS_FIRST     = 5'd0;
   localparam pos_type POS_CRC_FIRST = 5'd2;
   localparam pos_type POS_ECO2_HI   = 5'd9;
   localparam pos_type POS_ECO2_LO   = 5'd10;
   localparam pos_type POS_TVOC_HI   = 5'd11;
   localparam pos_type POS_TVOC_LO   = 5'd12;
   localparam pos_type POS_HCHO_HI   = 5'd13;
   localparam pos_type POS_HCHO_LO   = 5'd14;
   localparam pos_type POS_CRC_LO    = 5'd15;
   localparam pos_type POS_CRC_HI    = 5'd16;

   // crc-16/modbus
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // configuration register map (word index)
   localparam logic CSR_IDX_FULL_SET = 1'b0;
   localparam logic FULL_SET_RESET   = 1'b1;

   // scaling: x*123/100 and x*41/10, division by reciprocal multiplication
   localparam int HchoProdWidth  = 23;
   localparam int HchoRecipWidth = 25;
   localparam int HchoShift      = 31;
   localparam int HchoQuotWidth  = 17;
   localparam logic [6:0] HCHO_MUL = 7'd123;
   localparam logic [HchoRecipWidth-1:0] HCHO_RECIP = 25'd21474837;

   localparam int TvocProdWidth  = 22;
   localparam int TvocRecipWidth = 22;
   localparam int TvocShift      = 25;
   localparam int TvocQuotWidth  = 19;
   localparam logic [5:0] TVOC_MUL = 6'd41;
   localparam logic [TvocRecipWidth-1:0] TVOC_RECIP = 22'd3355444;

   // one byte through the reflected crc, lsb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                            input logic [7:0]  data);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage

FILE: sv/gscd_scale.sv
// ----------------------------------------------------------------------------
// gscd_scale
// Scales the captured tvoc and hcho words: product by the gain is registered
// one byte ahead, then the divide by 10 or 100 runs as a reciprocal multiply.
// ----------------------------------------------------------------------------
module gscd_scale (
   input  logic        clock,
   input  logic        load,
   input  logic [15:0] raw_tvoc,
   input  logic [15:0] raw_hcho,
   output logic [15:0] tvoc_scaled,
   output logic [15:0] hcho_scaled
);

   logic [gscd_pkg::HchoProdWidth-1:0] hcho_prod_ff;
   logic [gscd_pkg::HchoProdWidth-1:0] hcho_prod_in;
   logic [gscd_pkg::TvocProdWidth-1:0] tvoc_prod_ff;
   logic [gscd_pkg::TvocProdWidth-1:0] tvoc_prod_in;

   logic [gscd_pkg::HchoProdWidth+gscd_pkg::HchoRecipWidth-1:0] hcho_wide;
   logic [gscd_pkg::TvocProdWidth+gscd_pkg::TvocRecipWidth-1:0] tvoc_wide;
   logic [gscd_pkg::HchoQuotWidth-1:0] hcho_quot;
   logic [gscd_pkg::TvocQuotWidth-1:0] tvoc_quot;

   // gain products
   assign hcho_prod_in = gscd_pkg::HchoProdWidth'(raw_hcho) *
                         gscd_pkg::HchoProdWidth'(gscd_pkg::HCHO_MUL);
   assign tvoc_prod_in = gscd_pkg::TvocProdWidth'(raw_tvoc) *
                         gscd_pkg::TvocProdWidth'(gscd_pkg::TVOC_MUL);

   always_ff @(posedge clock) begin
      if (load) begin
         hcho_prod_ff <= hcho_prod_in;
         tvoc_prod_ff <= tvoc_prod_in;
      end
   end

   // divide by reciprocal, exact floor over the product range
   assign hcho_wide = {{gscd_pkg::HchoRecipWidth{1'b0}}, hcho_prod_ff} *
                      {{gscd_pkg::HchoProdWidth{1'b0}}, gscd_pkg::HCHO_RECIP};
   assign tvoc_wide = {{gscd_pkg::TvocRecipWidth{1'b0}}, tvoc_prod_ff} *
                      {{gscd_pkg::TvocProdWidth{1'b0}}, gscd_pkg::TVOC_RECIP};

   assign hcho_quot = hcho_wide[gscd_pkg::HchoShift +: gscd_pkg::HchoQuotWidth];
   assign tvoc_quot = tvoc_wide[gscd_pkg::TvocShift +: gscd_pkg::TvocQuotWidth];

   // saturate to 16 bits
   assign hcho_scaled = (|hcho_quot[gscd_pkg::HchoQuotWidth-1:16]) ? 16'hFFFF
                                                                    : hcho_quot[15:0];
   assign tvoc_scaled = (|tvoc_quot[gscd_pkg::TvocQuotWidth-1:16]) ? 16'hFFFF
                                                                    : tvoc_quot[15:0];

endmodule

FILE: sv/gas_sensor_frame_crc_decoder.sv
// ----------------------------------------------------------------------------
// gas_sensor_frame_crc_decoder
// Decodes 17-byte gas sensor reply frames, checks the crc-16/modbus and
// holds the last good eco2, tvoc and hcho readings.
// ----------------------------------------------------------------------------
// One frame byte is taken per beat; tuser high marks byte 0 and restarts the
// frame at any point. Each byte passes an input register and then the logic
// (byte-wide crc step, field capture), so the block takes a byte every cycle
// unless byte 16 waits for the result slot; the result is registered. Byte 16
// of a frame yields one result beat carrying the held readings and the crc
// verdict in tuser; other bytes yield none, and bytes past byte 16 are dropped
// until the next start. The tvoc and hcho gain products are computed on byte
// 15 and divided on byte 16. full_set_enable (register 0, reset 1) lets a
// good frame also update eco2 and tvoc; hcho is updated on every good frame.
module gas_sensor_frame_crc_decoder (
   input  logic        clock,
   input  logic        reset,

   // byte input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] frame_start

   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] eco2_ppm, [31:16] tvoc_scaled,
                                    // [47:32] hcho_scaled
   output logic        rsp_tuser,   // [0] crc_ok

   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   // frame state
   gscd_pkg::pos_type pos_ff;
   gscd_pkg::pos_type pos_in;
   gscd_pkg::pos_type pos_eff;
   logic [15:0]       crc_ff;
   logic [15:0]       crc_in;
   logic [15:0]       crc_base;
   logic [15:0]       eco2_raw_ff;
   logic [15:0]       tvoc_raw_ff;
   logic [15:0]       hcho_raw_ff;
   logic [7:0]        crc_lo_ff;

   // held results
   logic [15:0] held_eco2_ff;
   logic [15:0] held_tvoc_ff;
   logic [15:0] held_hcho_ff;
   logic        crc_ok_ff;
   logic        rsp_valid_ff;

   logic        full_set_ff;

   logic        step;
   logic        in_frame;
   logic        at_last;
   logic        crc_match;
   logic [15:0] tvoc_scaled;
   logic [15:0] hcho_scaled;

   // handshake: only the last byte of a frame waits for the result slot
   assign step        = in_valid_ff && (!at_last || !rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || step;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
   end

   // position and crc for this byte
   assign pos_eff  = in_start_ff ? gscd_pkg::POS_FIRST : pos_ff;
   assign in_frame = (pos_eff <= gscd_pkg::POS_CRC_HI);
   assign at_last  = (pos_eff == gscd_pkg::POS_CRC_HI);
   assign crc_base = (pos_eff == gscd_pkg::POS_FIRST) ? gscd_pkg::CRC_INIT : crc_ff;
   assign crc_in   = (pos_eff >= gscd_pkg::POS_CRC_FIRST && pos_eff <= gscd_pkg::POS_HCHO_LO)
                     ? gscd_pkg::crc_byte(crc_base, in_byte_ff) : crc_base;
   assign pos_in   = pos_eff + gscd_pkg::PosWidth'(1);
   assign crc_match = (crc_ff == {in_byte_ff, crc_lo_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= gscd_pkg::POS_FIRST;
         crc_ff <= gscd_pkg::CRC_INIT;
      end else if (step && in_frame) begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   // field capture
   always_ff @(posedge clock) begin
      if (step) begin
         unique case (pos_eff)
            gscd_pkg::POS_ECO2_HI: eco2_raw_ff[15:8] <= in_byte_ff;
            gscd_pkg::POS_ECO2_LO: eco2_raw_ff[7:0]  <= in_byte_ff;
            gscd_pkg::POS_TVOC_HI: tvoc_raw_ff[15:8] <= in_byte_ff;
            gscd_pkg::POS_TVOC_LO: tvoc_raw_ff[7:0]  <= in_byte_ff;
            gscd_pkg::POS_HCHO_HI: hcho_raw_ff[15:8] <= in_byte_ff;
            gscd_pkg::POS_HCHO_LO: hcho_raw_ff[7:0]  <= in_byte_ff;
            gscd_pkg::POS_CRC_LO:  crc_lo_ff         <= in_byte_ff;
            default: ;
         endcase
      end
   end

   // scaling, products loaded with the crc low byte
   gscd_scale u_scale (
      .clock       (clock),
      .load        (step && pos_eff == gscd_pkg::POS_CRC_LO),
      .raw_tvoc    (tvoc_raw_ff),
      .raw_hcho    (hcho_raw_ff),
      .tvoc_scaled (tvoc_scaled),
      .hcho_scaled (hcho_scaled)
   );

   // held readings double as the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         held_eco2_ff <= 16'h0000;
         held_tvoc_ff <= 16'h0000;
         held_hcho_ff <= 16'h0000;
      end else if (step && at_last && crc_match) begin
         held_hcho_ff <= hcho_scaled;
         if (full_set_ff) begin
            held_eco2_ff <= eco2_raw_ff;
            held_tvoc_ff <= tvoc_scaled;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && at_last) begin
         crc_ok_ff <= crc_match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && at_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {held_hcho_ff, held_tvoc_ff, held_eco2_ff};
   assign rsp_tuser  = crc_ok_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         full_set_ff <= gscd_pkg::FULL_SET_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == gscd_pkg::CSR_IDX_FULL_SET) begin
         full_set_ff <= csr_pwdata[0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == gscd_pkg::CSR_IDX_FULL_SET) ? {31'd0, full_set_ff}
                                                                 : 32'd0;

endmodule

FILE: test/tb_gas_sensor_frame_crc_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gas_sensor_frame_crc_decoder
// Byte-stream test of the gas sensor frame decoder: sends reply frames (good,
// bad crc, cut short, restarted, trailing junk) through the req stream,
// predicts the held readings and crc verdict of every completed frame, and
// compares each rsp beat field by field while both sides idle at random and
// full_set_enable is switched between phases.
// ----------------------------------------------------------------------------
module tb_gas_sensor_frame_crc_decoder;

   localparam int CycleLimit  = 200000;
   localparam int SettleDelay = 8;
   localparam int HoldCycles  = 300;
   localparam int PhaseBytes  = 406;

   // one result beat as the block reports it
   typedef struct packed {
      logic [15:0] eco2;
      logic [15:0] tvoc;
      logic [15:0] hcho;
      logic        crc_ok;
   } gas_reading_type;

   // frame decoder model plus queue of readings still due from the block
   class gas_frame_scoreboard;
      bit              full_set = gscd_pkg::FULL_SET_RESET;
      bit [4:0]        frame_pos = gscd_pkg::POS_FIRST;
      bit [15:0]       crc_acc = gscd_pkg::CRC_INIT;
      bit [15:0]       eco2_raw, tvoc_raw, hcho_raw;
      bit [7:0]        crc_lo;
      bit [15:0]       eco2_held, tvoc_held, hcho_held;
      gas_reading_type readings_due[$];
      int              error_count;

      function bit [15:0] crc16_step(bit [15:0] crc, bit [7:0] b);
         bit [15:0] c;
         c = crc ^ {8'h00, b};
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ gscd_pkg::CRC_POLY) : (c >> 1);
         end
         return c;
      endfunction

      function bit [15:0] clamp16(int unsigned v);
         return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
      endfunction

      function void flag_error(string msg);
         error_count++;
         if (error_count <= 10) begin
            $display("mismatch: %s", msg);
         end
      endfunction

      // returns 1 when the byte is taken into a frame, 0 when dropped
      function bit note_byte(bit [7:0] b, bit start);
         bit [4:0]        pos;
         gas_reading_type r;
         if (start) begin
            frame_pos = gscd_pkg::POS_FIRST;
         end
         pos = frame_pos;
         if (pos > gscd_pkg::POS_CRC_HI) begin
            return 0;
         end
         if (pos == gscd_pkg::POS_FIRST) begin
            crc_acc = gscd_pkg::CRC_INIT;
         end
         if (pos >= gscd_pkg::POS_CRC_FIRST && pos <= gscd_pkg::POS_HCHO_LO) begin
            crc_acc = crc16_step(crc_acc, b);
         end
         unique case (pos)
            gscd_pkg::POS_ECO2_HI: eco2_raw[15:8] = b;
            gscd_pkg::POS_ECO2_LO: eco2_raw[7:0] = b;
            gscd_pkg::POS_TVOC_HI: tvoc_raw[15:8] = b;
            gscd_pkg::POS_TVOC_LO: tvoc_raw[7:0] = b;
            gscd_pkg::POS_HCHO_HI: hcho_raw[15:8] = b;
            gscd_pkg::POS_HCHO_LO: hcho_raw[7:0] = b;
            gscd_pkg::POS_CRC_LO:  crc_lo = b;
            default: ;
         endcase
         frame_pos = 5'(pos + 5'd1);
         // last byte closes the frame with one result
         if (pos == gscd_pkg::POS_CRC_HI) begin
            r.crc_ok = (crc_acc == {b, crc_lo});
            if (r.crc_ok) begin
               hcho_held = clamp16((int'(hcho_raw) * 123) / 100);
               if (full_set) begin
                  eco2_held = eco2_raw;
                  tvoc_held = clamp16((int'(tvoc_raw) * 41) / 10);
               end
            end
            r.eco2 = eco2_held;
            r.tvoc = tvoc_held;
            r.hcho = hcho_held;
            readings_due.push_back(r);
         end
         return 1;
      endfunction

      function void check_result(logic [47:0] data, logic ok_bit);
         gas_reading_type want;
         if (readings_due.size() == 0) begin
            flag_error($sformatf("result with nothing pending: data=%h crc_ok=%b",
                                 data, ok_bit));
            return;
         end
         want = readings_due.pop_front();
         if (data[15:0] !== want.eco2) begin
            flag_error($sformatf("eco2_ppm expected %h got %h", want.eco2, data[15:0]));
         end
         if (data[31:16] !== want.tvoc) begin
            flag_error($sformatf("tvoc_scaled expected %h got %h", want.tvoc, data[31:16]));
         end
         if (data[47:32] !== want.hcho) begin
            flag_error($sformatf("hcho_scaled expected %h got %h", want.hcho, data[47:32]));
         end
         if (ok_bit !== want.crc_ok) begin
            flag_error($sformatf("crc_ok expected %b got %b", want.crc_ok, ok_bit));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] rx_byte
   logic        req_tuser = 1'b0;    // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;           // [15:0] eco2_ppm, [31:16] tvoc_scaled,
                                     // [47:32] hcho_scaled
   logic        rsp_tuser;           // [0] crc_ok
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic        csr_paddr = 1'b0;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   gas_frame_scoreboard sb = new();
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int taken_count = 0;
   int cycle_count = 0;
   bit hold_armed = 1'b0;
   logic rx_hold = 1'b0;

   gas_sensor_frame_crc_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("tb_gas_sensor_frame_crc_decoder: FAIL");
         $finish;
      end
   end

   // long receiver hold-off, armed once
   initial begin
      wait (hold_armed);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // result side ready with random stalls
   always @(posedge clock) begin
      rsp_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
   end

   // result beat check
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // one byte beat with a random gap in front
   task automatic send_byte(input bit [7:0] b, input bit start);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      if (sb.note_byte(b, start)) begin
         taken_count++;
      end
   endtask

   // reply frame with random header and filler, first n_bytes of it sent
   task automatic send_frame(input bit [15:0] eco2, input bit [15:0] tvoc,
                             input bit [15:0] hcho, input bit bad_crc,
                             input int n_bytes, input bit flagged);
      bit [7:0]  fr [17];
      bit [15:0] crc;
      foreach (fr[i]) begin
         fr[i] = 8'($urandom);
      end
      fr[gscd_pkg::POS_ECO2_HI] = eco2[15:8];
      fr[gscd_pkg::POS_ECO2_LO] = eco2[7:0];
      fr[gscd_pkg::POS_TVOC_HI] = tvoc[15:8];
      fr[gscd_pkg::POS_TVOC_LO] = tvoc[7:0];
      fr[gscd_pkg::POS_HCHO_HI] = hcho[15:8];
      fr[gscd_pkg::POS_HCHO_LO] = hcho[7:0];
      crc = gscd_pkg::CRC_INIT;
      for (int i = gscd_pkg::POS_CRC_FIRST; i <= gscd_pkg::POS_HCHO_LO; i++) begin
         crc = sb.crc16_step(crc, fr[i]);
      end
      if (bad_crc) begin
         crc ^= 16'($urandom_range(1, 65535));
      end
      fr[gscd_pkg::POS_CRC_LO] = crc[7:0];
      fr[gscd_pkg::POS_CRC_HI] = crc[15:8];
      for (int i = 0; i < n_bytes; i++) begin
         send_byte(fr[i], flagged && (i == 0));
      end
   endtask

   // readings biased toward zero, full scale and the saturation edges
   function automatic bit [15:0] pick_reading();
      unique case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(15980, 15990));
         3: return 16'($urandom_range(53275, 53290));
         default: return 16'($urandom);
      endcase
   endfunction

   // stop sending and wait out every pending result
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.readings_due.size() != 0) @(posedge clock);
      repeat (SettleDelay) @(posedge clock);
   endtask

   // write full_set_enable, then read it back
   task automatic write_full_set(input bit en);
      for (int acc = 0; acc < 2; acc++) begin
         @(posedge clock);
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= (acc == 0);
         csr_paddr   <= gscd_pkg::CSR_IDX_FULL_SET;
         csr_pwdata  <= {31'($urandom), en};
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (acc == 0) begin
            sb.full_set = en;
         end else if (csr_prdata[0] !== en) begin
            sb.flag_error($sformatf("full_set_enable readback expected %b got %b",
                                    en, csr_prdata[0]));
         end
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
      end
   endtask

   // mostly well-formed frames, some broken ones and noise
   task automatic run_phase(input int tx_pct, input int rx_pct);
      int start_count;
      int roll;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      start_count = taken_count;
      while (taken_count - start_count < PhaseBytes) begin
         roll = $urandom_range(99);
         if (roll < 85) begin
            send_frame(pick_reading(), pick_reading(), pick_reading(), roll >= 70, 17, 1'b1);
            // junk after the frame is dropped
            if ($urandom_range(9) == 0) begin
               repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
            end
         end else if (roll < 93) begin
            send_frame(pick_reading(), pick_reading(), pick_reading(), 1'b0,
                       $urandom_range(1, 16), 1'b1);
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(3) == 0);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // first frame right after reset without a start flag, full-scale readings
      send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 17, 1'b0);
      // bytes past the end of a frame
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      // frame cut short, restarted by the next start flag
      send_frame(pick_reading(), pick_reading(), pick_reading(), 1'b0, 5, 1'b1);
      wait_drained();

      // random phases with full_set_enable toggled in between
      write_full_set(1'b0);
      run_phase(24, 70);
      wait_drained();
      write_full_set(1'b1);
      run_phase(70, 24);
      wait_drained();
      write_full_set(1'b0);
      run_phase(0, 0);
      wait_drained();
      write_full_set(1'b1);
      hold_armed = 1'b1;
      run_phase(0, 0);
      wait_drained();

      if (sb.error_count == 0 && sb.readings_due.size() == 0) begin
         $display("tb_gas_sensor_frame_crc_decoder: PASS");
      end else begin
         $display("tb_gas_sensor_frame_crc_decoder: FAIL");
      end
      $finish;
   end

endmodule
